[sv/rqss_pkg.sv]
// ----------------------------------------------------------------------------
// rqss_pkg
// Shared types and constants for the record queue with sort and search.
// ----------------------------------------------------------------------------
package rqss_pkg;

  localparam int unsigned DEPTH   = 32;
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned MAX_OUT = 32;
  localparam int unsigned REC_W   = 32 + 64 + 16 + 40;

  typedef enum logic [2:0] {
    MODE_ADD    = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_SORT   = 3'd2,
    MODE_LIN    = 3'd3,
    MODE_BIN    = 3'd4,
    MODE_LIST   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FOUND    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_LISTED   = 3'd5
  } status_t;

  typedef struct packed {
    logic signed [31:0] number;
    logic [63:0]        date_high;
    logic [15:0]        date_low;
    logic [39:0]        time_chars;
  } rec_t;

  // Memory port request from the sequencer.
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    rec_t          wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SORT_RD_A,
    S_SORT_RD_B,
    S_SORT_CMP,
    S_SORT_WR,
    S_LIN_RD,
    S_LIN_CHK,
    S_BIN_RD,
    S_BIN_CHK,
    S_LIST_RD,
    S_LIST_OUT,
    S_OUT
  } state_t;

endpackage

[sv/rqss_ram.sv]
// ----------------------------------------------------------------------------
// rqss_ram
// Record storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rqss_ram
  import rqss_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output rec_t     rdata
);

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

[sv/record_queue_sort_search.sv]
// ----------------------------------------------------------------------------
// record_queue_sort_search
// Bounded FIFO of records with stable sort, linear and binary search, list.
// ----------------------------------------------------------------------------
// Flow: one beat is accepted at a time and the block stays busy until
// its last result beat is taken. Add, remove and unused modes go straight
// to the result state S_OUT. Sort is a bubble sort through the record
// memory: each compare reads two entries in S_SORT_RD_A and S_SORT_RD_B,
// compares them in S_SORT_CMP, and on a swap writes the pair back in
// S_SORT_CMP and S_SORT_WR. Linear search reads and checks one entry at a
// time in S_LIN_RD and S_LIN_CHK, binary search each probe in S_BIN_RD and
// S_BIN_CHK after its sort, and a listing reads each entry in S_LIST_RD and
// shows it from S_LIST_OUT, held by output stalls. Storage is circular:
// queue entry k lives in slot (head+k) mod DEPTH. Entries never written
// read as whatever the memory holds, but only occupied slots are ever read.
module record_queue_sort_search
  import rqss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         mode,
  input  logic signed [31:0] number,
  input  logic [63:0]        date_first8,
  input  logic [15:0]        date_last2,
  input  logic [39:0]        time_chars,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [31:0] found_number,
  output logic [63:0]        found_date_first8,
  output logic [15:0]        found_date_last2,
  output logic [39:0]        found_time_chars,
  output logic               last_of_run
);

  state_t state, state_next;

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [2:0]    op;
  logic signed [31:0] key;
  // Sort loop counters: limit is the pass end, idx the compare position.
  logic [CW-1:0] limit;
  logic [CW-1:0] idx;
  logic          swap;
  rec_t          rec_a;
  // Binary search bounds, signed so that hi can go below zero.
  logic signed [CW:0] lo, hi;
  logic [CW-1:0] mid;

  mem_req_t req;
  rec_t     rdata;

  rqss_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  logic accept_in, accept_out;
  assign accept_in  = in_valid && !in_stall;
  assign accept_out = out_valid && !out_stall;
  assign in_stall   = (state != S_IDLE);

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(k);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  logic [CW-1:0] mid_calc;
  logic [CW+1:0] lohi;
  assign lohi     = {lo[CW], lo} + {hi[CW], hi};
  assign mid_calc = lohi[CW:1];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept_in) begin
          if (mode == MODE_SORT || mode == MODE_BIN) begin
            state_next = (count >= CW'(2)) ? S_SORT_RD_A :
                         (mode == MODE_BIN && count != '0) ? S_BIN_RD : S_OUT;
          end else if (mode == MODE_LIN) begin
            state_next = (count != '0) ? S_LIN_RD : S_OUT;
          end else if (mode == MODE_LIST) begin
            state_next = (count != '0) ? S_LIST_RD : S_OUT;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_SORT_RD_A: state_next = S_SORT_RD_B;
      S_SORT_RD_B: state_next = S_SORT_CMP;
      S_SORT_CMP: begin
        if (swap) state_next = S_SORT_WR;
        else if (idx + CW'(2) < limit) state_next = S_SORT_RD_A;
        else if (limit > CW'(2)) state_next = S_SORT_RD_A;
        else state_next = (op == MODE_BIN) ? S_BIN_RD : S_OUT;
      end
      S_SORT_WR: begin
        if (idx + CW'(2) < limit) state_next = S_SORT_RD_A;
        else if (limit > CW'(2)) state_next = S_SORT_RD_A;
        else state_next = (op == MODE_BIN) ? S_BIN_RD : S_OUT;
      end
      S_LIN_RD:  state_next = S_LIN_CHK;
      S_LIN_CHK: begin
        if (rdata.number == key || idx + CW'(1) >= count) state_next = S_OUT;
        else state_next = S_LIN_RD;
      end
      S_BIN_RD:  state_next = S_BIN_CHK;
      S_BIN_CHK: begin
        if (rdata.number == key) state_next = S_OUT;
        else if (key < rdata.number) state_next = ($signed({1'b0, mid}) - 1 < lo) ? S_OUT : S_BIN_RD;
        else state_next = ($signed({1'b0, mid}) + 1 > hi) ? S_OUT : S_BIN_RD;
      end
      S_LIST_RD:  state_next = S_LIST_OUT;
      S_LIST_OUT: begin
        if (accept_out) state_next = last_of_run ? S_IDLE : S_LIST_RD;
      end
      S_OUT: if (accept_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory requests.
  always_comb begin
    req = '0;
    req.wdata = rec_a;
    unique case (state)
      S_IDLE: begin
        req.we    = accept_in && mode == MODE_ADD && count < CW'(DEPTH);
        req.waddr = slot(head, count);
        req.wdata = '{number, date_first8, date_last2, time_chars};
      end
      S_SORT_RD_A: req.raddr = slot(head, idx);
      S_SORT_RD_B: req.raddr = slot(head, idx + CW'(1));
      S_SORT_CMP: begin
        // Put b into slot idx; a follows next cycle.
        req.we    = swap;
        req.waddr = slot(head, idx);
        req.wdata = rdata;
      end
      S_SORT_WR: begin
        req.we    = 1'b1;
        req.waddr = slot(head, idx + CW'(1));
        req.wdata = rec_a;
      end
      S_LIN_RD:  req.raddr = slot(head, idx);
      S_BIN_RD:  req.raddr = slot(head, mid_calc);
      S_LIST_RD: req.raddr = slot(head, idx);
      default: ;
    endcase
  end

  always_comb swap = (rec_a.number > rdata.number);

  // Sequencing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (accept_in) begin
          op    <= mode;
          key   <= number;
          idx   <= '0;
          limit <= count;
          lo    <= '0;
          hi    <= $signed({1'b0, count}) - (CW+1)'(1);
          found_number      <= '0;
          found_date_first8 <= '0;
          found_date_last2  <= '0;
          found_time_chars  <= '0;
          last_of_run       <= 1'b1;
          unique case (mode)
            MODE_ADD: begin
              if (count < CW'(DEPTH)) begin
                count <= count + CW'(1);
                status <= ST_DONE;
              end else status <= ST_FULL;
            end
            MODE_REMOVE: begin
              if (count != '0) begin
                head  <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
                count <= count - CW'(1);
                status <= ST_DONE;
              end else status <= ST_EMPTY;
            end
            MODE_LIN: status <= ST_NOTFOUND;
            MODE_BIN: status <= (count == '0) ? ST_EMPTY : ST_NOTFOUND;
            MODE_LIST: status <= ST_EMPTY;
            default: status <= ST_DONE;
          endcase
        end
        S_SORT_RD_B: ;
        S_SORT_CMP: begin
          if (!swap) begin
            if (idx + CW'(2) < limit) idx <= idx + CW'(1);
            else begin
              idx <= '0;
              limit <= limit - CW'(1);
            end
          end
        end
        S_SORT_WR: begin
          if (idx + CW'(2) < limit) idx <= idx + CW'(1);
          else begin
            idx <= '0;
            limit <= limit - CW'(1);
          end
        end
        S_LIN_CHK: begin
          if (rdata.number == key) begin
            status <= ST_FOUND;
            found_number      <= rdata.number;
            found_date_first8 <= rdata.date_high;
            found_date_last2  <= rdata.date_low;
            found_time_chars  <= rdata.time_chars;
          end
          idx <= idx + CW'(1);
        end
        S_BIN_RD: mid <= mid_calc;
        S_BIN_CHK: begin
          if (rdata.number == key) begin
            status <= ST_FOUND;
            found_number      <= rdata.number;
            found_date_first8 <= rdata.date_high;
            found_date_last2  <= rdata.date_low;
            found_time_chars  <= rdata.time_chars;
          end else if (key < rdata.number) hi <= $signed({1'b0, mid}) - (CW+1)'(1);
          else lo <= $signed({1'b0, mid}) + (CW+1)'(1);
        end
        S_LIST_OUT: begin
          // The entry read in S_LIST_RD is on rdata during the first cycle here.
          if (!out_valid) begin
            status            <= ST_LISTED;
            found_number      <= rdata.number;
            found_date_first8 <= rdata.date_high;
            found_date_last2  <= rdata.date_low;
            found_time_chars  <= rdata.time_chars;
            last_of_run <= (idx + CW'(1) >= count) || (idx + CW'(1) >= CW'(MAX_OUT));
            idx <= idx + CW'(1);
          end
        end
        default: ;
      endcase
      // Data from the memory lands in the cycle after the read request.
      if (state == S_SORT_RD_B) rec_a <= rdata;
      if (accept_out) out_valid <= 1'b0;
      else if ((state_next == S_OUT && state != S_OUT) ||
               (state == S_LIST_OUT && !out_valid)) out_valid <= 1'b1;
    end
  end

  // Assertions.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept_in |-> state == S_IDLE) else $error("input accepted while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("entry count overflow");
  a_out_only_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT || state == S_LIST_OUT))
    else $error("result shown while idle");

endmodule

[sim/record_queue_sort_search_chk.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_queue_sort_search_chk
// Watches both channels of the record queue, keeps its own copy of the
// queue, and compares every result beat with the predicted one.
// ----------------------------------------------------------------------------
module record_queue_sort_search_chk
  import rqss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         mode,
  input  logic signed [31:0] number,
  input  logic [63:0]        date_first8,
  input  logic [15:0]        date_last2,
  input  logic [39:0]        time_chars,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         status,
  input  logic signed [31:0] found_number,
  input  logic [63:0]        found_date_first8,
  input  logic [15:0]        found_date_last2,
  input  logic [39:0]        found_time_chars,
  input  logic               last_of_run,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    status_t st;
    rec_t    r;
    logic    last;
  } reply_t;

  rec_t   slots [DEPTH];
  int     head, count;
  reply_t replies_due [$];

  function automatic int slot_of(int k);
    return (head + k) % DEPTH;
  endfunction

  function automatic reply_t reply(status_t st, rec_t r, logic last);
    reply_t x;
    x.st = st; x.r = r; x.last = last;
    return x;
  endfunction

  // Stable ascending bubble sort on the number field.
  task automatic sort_records();
    rec_t a;
    for (int p = 0; p + 1 < count; p++)
      for (int i = 0; i + 1 < count - p; i++) begin
        a = slots[slot_of(i)];
        if (a.number > slots[slot_of(i + 1)].number) begin
          slots[slot_of(i)] = slots[slot_of(i + 1)];
          slots[slot_of(i + 1)] = a;
        end
      end
  endtask

  task automatic predict_replies(logic [2:0] m, rec_t in);
    rec_t z, r;
    int lo, hi, mid, n;
    bit hit;
    z = '0;
    hit = 0;
    case (m)
      MODE_ADD: begin
        if (count >= DEPTH) replies_due.push_back(reply(ST_FULL, z, 1));
        else begin
          slots[slot_of(count)] = in;
          count++;
          replies_due.push_back(reply(ST_DONE, z, 1));
        end
      end
      MODE_REMOVE: begin
        if (count == 0) replies_due.push_back(reply(ST_EMPTY, z, 1));
        else begin
          head = (head + 1) % DEPTH;
          count--;
          replies_due.push_back(reply(ST_DONE, z, 1));
        end
      end
      MODE_SORT: begin
        sort_records();
        replies_due.push_back(reply(ST_DONE, z, 1));
      end
      MODE_LIN: begin
        for (int i = 0; i < count && !hit; i++)
          if (slots[slot_of(i)].number == in.number) begin
            hit = 1;
            replies_due.push_back(reply(ST_FOUND, slots[slot_of(i)], 1));
          end
        if (!hit) replies_due.push_back(reply(ST_NOTFOUND, z, 1));
      end
      MODE_BIN: begin
        sort_records();
        if (count == 0) replies_due.push_back(reply(ST_EMPTY, z, 1));
        else begin
          lo = 0;
          hi = count - 1;
          while (lo <= hi && !hit) begin
            mid = (lo + hi) / 2;
            r = slots[slot_of(mid)];
            if (r.number == in.number) begin
              hit = 1;
              replies_due.push_back(reply(ST_FOUND, r, 1));
            end else if (in.number < r.number) hi = mid - 1;
            else lo = mid + 1;
          end
          if (!hit) replies_due.push_back(reply(ST_NOTFOUND, z, 1));
        end
      end
      MODE_LIST: begin
        n = (count > MAX_OUT) ? MAX_OUT : count;
        if (n == 0) replies_due.push_back(reply(ST_EMPTY, z, 1));
        for (int i = 0; i < n; i++)
          replies_due.push_back(reply(ST_LISTED, slots[slot_of(i)], i + 1 == n));
      end
      default: replies_due.push_back(reply(ST_DONE, z, 1));
    endcase
  endtask

  always @(posedge clk) begin
    rec_t in;
    reply_t e;
    if (rst) begin
      head = 0;
      count = 0;
      fail_count = 0;
      replies_due.delete();
      pending <= 0;
    end else begin
      // The result side is checked against predictions made on earlier beats.
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("result beat with no prediction waiting");
          fail_count++;
        end else begin
          e = replies_due.pop_front();
          if (status !== e.st) begin
            $error("status: expected %0d actual %0d", e.st, status); fail_count++;
          end
          if (found_number !== e.r.number) begin
            $error("found_number: expected %0d actual %0d", e.r.number, found_number);
            fail_count++;
          end
          if (found_date_first8 !== e.r.date_high) begin
            $error("found_date_first8: expected %h actual %h", e.r.date_high,
                   found_date_first8);
            fail_count++;
          end
          if (found_date_last2 !== e.r.date_low) begin
            $error("found_date_last2: expected %h actual %h", e.r.date_low,
                   found_date_last2);
            fail_count++;
          end
          if (found_time_chars !== e.r.time_chars) begin
            $error("found_time_chars: expected %h actual %h", e.r.time_chars,
                   found_time_chars);
            fail_count++;
          end
          if (last_of_run !== e.last) begin
            $error("last_of_run: expected %0d actual %0d", e.last, last_of_run);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        in.number = number;
        in.date_high = date_first8;
        in.date_low = date_last2;
        in.time_chars = time_chars;
        predict_replies(mode, in);
      end
      pending <= replies_due.size();
    end
  end

endmodule

[sim/record_queue_sort_search_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_queue_sort_search_tb
// Drives directed and random queue operations into the record queue under
// several idling phases; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module record_queue_sort_search_tb;
  import rqss_pkg::*;

  // The watchdog allows ample room for a full sort of 32 entries and for a
  // 32-beat listing under heavy stall.
  localparam int QUIET_LIMIT = 40000;

  logic               clk, rst;
  logic               in_valid, in_stall, out_valid, out_stall;
  logic [2:0]         mode, status;
  logic signed [31:0] number, found_number;
  logic [63:0]        date_first8, found_date_first8;
  logic [15:0]        date_last2, found_date_last2;
  logic [39:0]        time_chars, found_time_chars;
  logic               last_of_run;
  int                 fail_count, pending;
  int                 send_idle_pct, stall_pct;
  int                 quiet_cycles;

  record_queue_sort_search dut (.*);
  record_queue_sort_search_chk checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk)
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);

  // The watchdog counts cycles with no beat accepted on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Sends one beat, with an optional random idle gap in front of it, and
  // holds it until the block takes it. Valid stays up after the accepting
  // edge so that a following beat can go out with no gap.
  task automatic send_beat(logic [2:0] m, logic signed [31:0] num, logic [63:0] dhi,
                           logic [15:0] dlo, logic [39:0] tm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    number      <= num;
    date_first8 <= dhi;
    date_last2  <= dlo;
    time_chars  <= tm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic add_random(logic signed [31:0] num);
    send_beat(MODE_ADD, num, {$urandom, $urandom}, 16'($urandom),
              40'({$urandom, $urandom}));
  endtask

  // Keys drawn from a narrow range make duplicates and search hits common;
  // a few come from the whole signed range.
  function automatic logic signed [31:0] pick_key();
    return ($urandom_range(9) == 0) ? $signed($urandom) : $urandom_range(40) - 20;
  endfunction

  task automatic random_beat();
    int r;
    r = $urandom_range(99);
    if (r < 40) add_random(pick_key());
    else if (r < 55) send_beat(MODE_REMOVE, $urandom, 0, 0, 0);
    else if (r < 62) send_beat(MODE_SORT, $urandom, 0, 0, 0);
    else if (r < 75) send_beat(MODE_LIN, pick_key(), 0, 0, 0);
    else if (r < 87) send_beat(MODE_BIN, pick_key(), 0, 0, 0);
    else if (r < 96) send_beat(MODE_LIST, $urandom, 0, 0, 0);
    else send_beat(3'($urandom_range(7, 6)), $urandom, {$urandom, $urandom},
                   16'($urandom), 40'({$urandom, $urandom}));
  endtask

  initial begin
    in_valid = 0; mode = '0; number = '0;
    date_first8 = '0; date_last2 = '0; time_chars = '0;
    send_idle_pct = 0; stall_pct = 0;
    rst = 1;
    repeat (9) @(posedge clk);
    rst <= 0;

    // Directed part: operations on an empty queue, field extremes, a full
    // queue with a dropped add, and the unused modes.
    send_beat(MODE_REMOVE, 0, 0, 0, 0);
    send_beat(MODE_SORT, 0, 0, 0, 0);
    send_beat(MODE_LIN, 0, 0, 0, 0);
    send_beat(MODE_BIN, 0, 0, 0, 0);
    send_beat(MODE_LIST, 0, 0, 0, 0);
    send_beat(3'd6, 0, 0, 0, 0);
    send_beat(3'd7, '1, '1, '1, '1);
    send_beat(MODE_ADD, 32'sh7fffffff, '1, '1, '1);
    send_beat(MODE_ADD, 32'sh80000000, '0, '0, '0);
    send_beat(MODE_ADD, -1, 64'h3230323530313031, 16'h3233, 40'h31323a3030);
    send_beat(MODE_LIN, -1, 0, 0, 0);
    send_beat(MODE_LIST, 0, 0, 0, 0);
    send_beat(MODE_BIN, 32'sh80000000, 0, 0, 0);
    send_beat(MODE_BIN, 5, 0, 0, 0);
    send_beat(MODE_REMOVE, 0, 0, 0, 0);
    for (int i = 0; i < DEPTH; i++) add_random($urandom_range(5));
    send_beat(MODE_ADD, 1, 1, 1, 1);
    send_beat(MODE_LIST, 0, 0, 0, 0);
    send_beat(MODE_BIN, 3, 0, 0, 0);
    send_beat(MODE_LIN, 2, 0, 0, 0);
    in_valid <= 1'b0;
    @(posedge clk);
    while (checker_i.pending != 0) @(posedge clk);
    repeat (DEPTH) send_beat(MODE_REMOVE, 0, 0, 0, 0);

    // Random part in four idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 78 : 19) : 0;
      stall_pct     = (ph == 2 || ph == 3) ? ((ph == 2) ? 78 : 19) : 0;
      repeat (125) random_beat();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
